// File: hw/rtl/tnes_pkg.sv
// ----------------------------------------------------------------------------
// tnes_pkg
// Types and constants shared by the timed note event scheduler.
// ----------------------------------------------------------------------------
package tnes_pkg;

  localparam int KeyW       = 8;
  localparam int StampW     = 32;
  localparam int EntryW     = KeyW + 1 + StampW;
  localparam int CountW     = 6;

  localparam logic [CountW-1:0] MaxResults   = 6'd33;
  localparam logic [KeyW-1:0]   KeyCount     = 8'd88;
  localparam logic [6:0]        KeyShift     = 7'd8;
  localparam logic [6:0]        SkipAbove    = 7'd80;
  localparam logic [6:0]        ChannelLimit = 7'd96;

  typedef enum logic [2:0] {
    OP_NOOP    = 3'd0,
    OP_NOTE    = 3'd1,
    OP_ALL_OFF = 3'd2,
    OP_START   = 3'd3,
    OP_PAUSE   = 3'd4,
    OP_RESUME  = 3'd5,
    OP_RESTART = 3'd6,
    OP_TICK    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_FLUSH
  } state_t;

  typedef enum logic {
    KIND_DRIVE = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] board;
    logic [3:0] pin;
    logic       drive_on;
  } result_t;

  localparam result_t ClearAll = '{kind: KIND_CLEAR, board: 3'd0, pin: 4'd0, drive_on: 1'b0};

endpackage

// File: hw/rtl/timed_note_event_scheduler_top.sv
// ----------------------------------------------------------------------------
// timed_note_event_scheduler_top
// Command-driven note queue with playback clock; due notes in key and channel
// range become solenoid drive beats, all-off and pause while playing become clear-all beats.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   cmd     | in        | cmd_valid/cmd_stall | operation, key, press, stamp
//   evt     | out       | evt_valid/evt_stall | kind, board, pin, drive_on, last
//
// A command passes through accept, a queue check and a flush; each popped
// note adds a head read through the registered queue RAM and another check,
// and a drain that stops at a head that is not yet due also reads it first.
// cmd_stall is high after accept until the flush ends, which loads any
// pending last beat into the output register. Output stalls hold the
// sequencer when a new drive is found while the previous one still waits,
// and in flush until the final beat can be loaded.
// Reset is synchronous; the queue RAM needs no clearing.
// ----------------------------------------------------------------------------
module timed_note_event_scheduler_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  key,
  input  logic [7:0]  press,
  input  logic [31:0] stamp,
  output logic        evt_valid,
  input  logic        evt_stall,
  output logic        kind,
  output logic [2:0]  board,
  output logic [3:0]  pin,
  output logic        drive_on,
  output logic        last
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [tnes_pkg::CountW-1:0] DepthC = tnes_pkg::CountW'(QUEUE_DEPTH);
  localparam logic [AW:0] DepthW = (AW+1)'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(QUEUE_DEPTH - 1);

  tnes_pkg::state_t state, state_next;

  logic                          playing;
  logic [31:0]                   playback_time;
  logic [tnes_pkg::CountW-1:0]   count;
  logic [AW-1:0]                 head;
  logic [tnes_pkg::CountW-1:0]   n;
  logic                          pend_valid;
  tnes_pkg::result_t             pend;

  logic                          accept;
  logic                          out_free;
  logic [AW:0]                   tail_sum;
  logic [AW-1:0]                 tail;
  logic [tnes_pkg::CountW-1:0]   count_inc;
  logic [tnes_pkg::EntryW-1:0]   wdata;
  logic [tnes_pkg::EntryW-1:0]   rdata;
  logic [7:0]                    rd_key;
  logic                          rd_on;
  logic [31:0]                   rd_time;
  logic [6:0]                    ch_base;
  logic [6:0]                    ch;
  logic                          due;
  logic                          hit;
  logic                          blocked;
  logic                          more;
  tnes_pkg::result_t             found;

  logic ram_we;
  logic ram_re;
  logic pop;
  logic push_mid;
  logic push_last;

  assign accept   = cmd_valid && !cmd_stall;
  assign out_free = !evt_valid || !evt_stall;

  assign tail_sum  = (AW+1)'(head) + (AW+1)'(count);
  assign tail      = (tail_sum >= DepthW) ? AW'(tail_sum - DepthW) : tail_sum[AW-1:0];
  assign count_inc = count + 1'b1;
  assign wdata     = {key, (press != 8'd0), stamp};

  assign rd_key  = rdata[tnes_pkg::EntryW-1 -: 8];
  assign rd_on   = rdata[32];
  assign rd_time = rdata[31:0];

  assign ch_base = 7'(rd_key) + tnes_pkg::KeyShift;
  assign ch      = (ch_base > tnes_pkg::SkipAbove) ? ch_base + 7'd1 : ch_base;
  assign due     = rd_time <= playback_time;
  assign hit     = due && (rd_key < tnes_pkg::KeyCount) && (ch < tnes_pkg::ChannelLimit);
  assign blocked = hit && pend_valid && !out_free;
  assign more    = playing && (count != '0) && (n < tnes_pkg::MaxResults);

  assign found = '{kind: tnes_pkg::KIND_DRIVE, board: ch[6:4], pin: ~ch[3:0], drive_on: rd_on};

  tnes_ram #(
    .WIDTH(tnes_pkg::EntryW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(head),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      tnes_pkg::ST_IDLE: begin
        if (accept) state_next = tnes_pkg::ST_CHECK;
      end
      tnes_pkg::ST_CHECK: begin
        state_next = more ? tnes_pkg::ST_READ : tnes_pkg::ST_FLUSH;
      end
      tnes_pkg::ST_READ: begin
        if (!due) begin
          state_next = tnes_pkg::ST_FLUSH;
        end else if (!blocked) begin
          state_next = tnes_pkg::ST_CHECK;
        end
      end
      tnes_pkg::ST_FLUSH: begin
        if (!pend_valid || out_free) state_next = tnes_pkg::ST_IDLE;
      end
      default: state_next = tnes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall = (state != tnes_pkg::ST_IDLE);
    ram_we    = accept && (tnes_pkg::op_t'(operation) == tnes_pkg::OP_NOTE);
    ram_re    = (state == tnes_pkg::ST_CHECK);
    pop       = (state == tnes_pkg::ST_READ) && due && !blocked;
    push_mid  = pop && hit && pend_valid;
    push_last = (state == tnes_pkg::ST_FLUSH) && pend_valid && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tnes_pkg::ST_IDLE;
      playing       <= 1'b0;
      playback_time <= '0;
      count         <= '0;
      head          <= '0;
      n             <= '0;
      pend_valid    <= 1'b0;
      evt_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (accept) begin
        n <= ((tnes_pkg::op_t'(operation) == tnes_pkg::OP_ALL_OFF) ||
              ((tnes_pkg::op_t'(operation) == tnes_pkg::OP_PAUSE) && playing)) ? 6'd1 : '0;
        case (tnes_pkg::op_t'(operation))
          tnes_pkg::OP_NOTE: begin
            count <= (count_inc == DepthC) ? '0 : count_inc;
          end
          tnes_pkg::OP_ALL_OFF: begin
            pend       <= tnes_pkg::ClearAll;
            pend_valid <= 1'b1;
          end
          tnes_pkg::OP_PAUSE: begin
            if (playing) begin
              pend       <= tnes_pkg::ClearAll;
              pend_valid <= 1'b1;
              playing    <= 1'b0;
            end
          end
          tnes_pkg::OP_RESUME: begin
            if (!playing) begin
              playing       <= 1'b1;
              playback_time <= stamp;
            end
          end
          tnes_pkg::OP_RESTART: begin
            count         <= '0;
            playback_time <= '0;
          end
          tnes_pkg::OP_TICK: begin
            if (playing) playback_time <= playback_time + 32'd1;
          end
          default: ;
        endcase
      end

      if (pop) begin
        head  <= (head == LastAddr) ? '0 : head + 1'b1;
        count <= count - 1'b1;
        if (hit) begin
          pend       <= found;
          pend_valid <= 1'b1;
          n          <= n + 1'b1;
        end
      end

      if (push_mid || push_last) begin
        evt_valid <= 1'b1;
        kind      <= pend.kind;
        board     <= pend.board;
        pin       <= pend.pin;
        drive_on  <= pend.drive_on;
        last      <= push_last;
        if (push_last) pend_valid <= 1'b0;
      end else if (evt_valid && !evt_stall) begin
        evt_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/tnes_ram.sv
// ----------------------------------------------------------------------------
// tnes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tnes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
